[rtl/core/dlc_pkg.sv]
// Shared types, widths, reset values and register codes for the depth
// linearize and clamp block. No dependencies.
`default_nettype none
package dlc_pkg;

    localparam int DLC_DEPTH_BITS = 24;
    localparam int DLC_REG_W      = 32;
    localparam int DLC_IDX_W      = 3;
    localparam int DLC_DEN_W      = 37;
    localparam int DLC_QUO_W      = 32;
    localparam int DLC_CODE_W     = 16;
    localparam int DLC_NDC_ONE    = 32;

    localparam logic [DLC_IDX_W-1:0] REG_NDC_BASE      = 3'd0;
    localparam logic [DLC_IDX_W-1:0] REG_NDC_NUMERATOR = 3'd1;
    localparam logic [DLC_IDX_W-1:0] REG_CLIP_NEAR     = 3'd2;
    localparam logic [DLC_IDX_W-1:0] REG_CLIP_FAR      = 3'd3;
    localparam logic [DLC_IDX_W-1:0] REG_RANGE_SCALE   = 3'd4;

    localparam logic [DLC_REG_W-1:0] RST_NDC_BASE      = 32'd270540833;
    localparam logic [DLC_REG_W-1:0] RST_NDC_NUMERATOR = 32'd526343;
    localparam logic [DLC_REG_W-1:0] RST_CLIP_NEAR     = 32'd262144;
    localparam logic [DLC_REG_W-1:0] RST_CLIP_FAR      = 32'd131072000;
    localparam logic [DLC_REG_W-1:0] RST_RANGE_SCALE   = 32'd2151754;

    localparam logic [DLC_CODE_W-1:0] DLC_CODE_MAX  = 16'hFFFF;
    localparam logic [DLC_CODE_W-1:0] DLC_CODE_ZERO = 16'h0000;

    typedef struct packed {
        logic                 sat;
        logic [DLC_DEN_W-1:0] den;
        logic [DLC_DEN_W-1:0] rem;
        logic [DLC_QUO_W-1:0] quo;
    } t_div_bus;

    typedef struct packed {
        logic sat;
        logic le_near;
        logic ge_far;
    } t_clip_flags;

    function automatic t_div_bus div_step(input t_div_bus b);
        logic [DLC_DEN_W:0] rem2;
        t_div_bus           r;
        r    = b;
        rem2 = {b.rem, 1'b0};
        if (rem2 >= {1'b0, b.den}) begin
            rem2  = rem2 - {1'b0, b.den};
            r.quo = {b.quo[DLC_QUO_W-2:0], 1'b1};
        end else begin
            r.quo = {b.quo[DLC_QUO_W-2:0], 1'b0};
        end
        r.rem = rem2[DLC_DEN_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/dlc_front.sv]
// Front stages: divisor build from the sample and ndc_base, then the
// numerator range check. Depends on dlc_pkg.
`default_nettype none
module dlc_front
    import dlc_pkg::*;
#(
    parameter int DEPTH_BITS = DLC_DEPTH_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DEPTH_BITS-1:0] i_sample,
    input  wire logic [DLC_REG_W-1:0]  i_base,
    input  wire logic [DLC_REG_W-1:0]  i_num,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_div_bus                   o_bus
);

    localparam int SUB_SHIFT = 33 - DEPTH_BITS;

    logic                 r_a_v;
    logic                 r_a_sat;
    logic [DLC_DEN_W-1:0] r_a_den;
    logic                 r_b_v;
    t_div_bus             r_b;
    logic                 w_en_a;
    logic                 w_en_b;
    logic [DLC_DEN_W-1:0] w_add;
    logic [DLC_DEN_W-1:0] w_sub;
    t_div_bus             n_b;

    assign w_en_b  = !r_b_v || i_ready;
    assign w_en_a  = !r_a_v || w_en_b;
    assign o_ready = w_en_a;
    assign o_valid = r_b_v;
    assign o_bus   = r_b;

    assign w_add = {1'b0, i_base, 4'b0000} + (DLC_DEN_W'(1) << DLC_NDC_ONE);
    assign w_sub = DLC_DEN_W'(i_sample) << SUB_SHIFT;

    always_comb begin
        n_b     = '0;
        n_b.sat = r_a_sat || (DLC_DEN_W'(i_num) >= r_a_den);
        n_b.den = r_a_den;
        n_b.rem = DLC_DEN_W'(i_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_v <= i_valid;
            end
            if (w_en_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_sat <= (w_add <= w_sub);
            r_a_den <= w_add - w_sub;
        end
        if (w_en_b) begin
            r_b <= n_b;
        end
    end

endmodule
`default_nettype wire

[rtl/core/dlc_divider.sv]
// Restoring divider, one quotient bit per register stage, 32 stages.
// Depends on dlc_pkg.
`default_nettype none
module dlc_divider
    import dlc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_div_bus i_bus,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_div_bus      o_bus
);

    localparam int NSTG = DLC_QUO_W;

    logic     r_v   [NSTG];
    t_div_bus r_bus [NSTG];
    logic     w_en  [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic     w_vin;
        logic     w_next_en;
        t_div_bus w_src;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            assign w_src = i_bus;
        end else begin : g_rest
            assign w_vin = r_v[k-1];
            assign w_src = r_bus[k-1];
        end

        if (k == NSTG - 1) begin : g_last
            assign w_next_en = i_ready;
        end else begin : g_mid
            assign w_next_en = w_en[k+1];
        end

        assign w_en[k] = !r_v[k] || w_next_en;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_bus[k] <= div_step(w_src);
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_bus   = r_bus[NSTG-1];

endmodule
`default_nettype wire

[rtl/core/dlc_back.sv]
// Back stages: clip compares, range scaling multiply, saturation and byte
// swap into the output register. Depends on dlc_pkg.
`default_nettype none
module dlc_back
    import dlc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_div_bus              i_bus,
    input  wire logic [DLC_REG_W-1:0]  i_near,
    input  wire logic [DLC_REG_W-1:0]  i_far,
    input  wire logic [DLC_REG_W-1:0]  i_scale,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DLC_CODE_W-1:0]      o_code_swapped
);

    logic                    r_c_v;
    t_clip_flags             r_c_flags;
    logic [DLC_QUO_W-1:0]    r_c_diff;
    logic                    r_m_v;
    t_clip_flags             r_m_flags;
    logic [DLC_REG_W-1:0]    r_m_hi;
    logic                    r_o_v;
    logic [DLC_CODE_W-1:0]   r_o_code;
    logic                    w_en_c;
    logic                    w_en_m;
    logic                    w_en_o;
    t_clip_flags             n_c_flags;
    logic [2*DLC_REG_W-1:0]  w_prod;
    logic [DLC_CODE_W-1:0]   n_code;

    assign w_en_o  = !r_o_v || i_ready;
    assign w_en_m  = !r_m_v || w_en_o;
    assign w_en_c  = !r_c_v || w_en_m;
    assign o_ready = w_en_c;
    assign o_valid = r_o_v;
    assign o_code_swapped = r_o_code;

    always_comb begin
        n_c_flags.sat     = i_bus.sat;
        n_c_flags.le_near = i_bus.quo <= i_near;
        n_c_flags.ge_far  = i_bus.quo >= i_far;
    end

    assign w_prod = (2*DLC_REG_W)'(r_c_diff) * (2*DLC_REG_W)'(i_scale);

    always_comb begin
        if (r_m_flags.sat) begin
            n_code = DLC_CODE_MAX;
        end else if (r_m_flags.le_near) begin
            n_code = DLC_CODE_ZERO;
        end else if (r_m_flags.ge_far) begin
            n_code = DLC_CODE_MAX;
        end else if (|r_m_hi[DLC_REG_W-1:DLC_CODE_W]) begin
            n_code = DLC_CODE_MAX;
        end else begin
            n_code = r_m_hi[DLC_CODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_en_c) begin
                r_c_v <= i_valid;
            end
            if (w_en_m) begin
                r_m_v <= r_c_v;
            end
            if (w_en_o) begin
                r_o_v <= r_m_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_flags <= n_c_flags;
            r_c_diff  <= i_bus.quo - i_near;
        end
        if (w_en_m) begin
            r_m_flags <= r_c_flags;
            r_m_hi    <= w_prod[2*DLC_REG_W-1:DLC_REG_W];
        end
        if (w_en_o) begin
            r_o_code <= {n_code[7:0], n_code[15:8]};
        end
    end

endmodule
`default_nettype wire

[rtl/core/depth_linearize_clamp_16bit.sv]
// Depth linearize and clamp: 37-stage pipeline turning normalized depth
// samples into byte-swapped 16-bit linear codes.
// Depends on dlc_pkg, dlc_front, dlc_divider, dlc_back.
//
// Usage:
//   Sample channel: i_depth_valid / o_depth_ready carry i_depth_sample.
//   Code channel:   o_code_valid / i_code_ready carry o_depth_code_swapped.
//   Config port:    i_cfg_we writes i_cfg_wdata into register i_cfg_idx
//                   (0 ndc_base, 1 ndc_numerator, 2 clip_near, 3 clip_far,
//                   4 range_scale); other indexes are ignored. Write only
//                   while the pipeline is empty.
//   Stages from accepted sample to code valid: 2 front stages,
//   one stage per quotient bit of the 32-bit divider, 3 back stages.
//   Throughput: one sample per clock when not stalled; depth set by divider.
//   Reset: synchronous, active low; empties all stages and loads the
//   register defaults.
//   Stall: each stage holds while its successor is full and held, so bubbles
//   close up and samples keep entering until every stage is occupied.
`default_nettype none
module depth_linearize_clamp_16bit
    import dlc_pkg::*;
#(
    parameter int DEPTH_BITS = DLC_DEPTH_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_depth_valid,
    output logic                       o_depth_ready,
    input  wire logic [DEPTH_BITS-1:0] i_depth_sample,
    output logic                       o_code_valid,
    input  wire logic                  i_code_ready,
    output logic [DLC_CODE_W-1:0]      o_depth_code_swapped,
    input  wire logic                  i_cfg_we,
    input  wire logic [DLC_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [DLC_REG_W-1:0]  i_cfg_wdata
);

    logic [DLC_REG_W-1:0] r_ndc_base;
    logic [DLC_REG_W-1:0] r_ndc_numerator;
    logic [DLC_REG_W-1:0] r_clip_near;
    logic [DLC_REG_W-1:0] r_clip_far;
    logic [DLC_REG_W-1:0] r_range_scale;

    logic     w_f_valid;
    logic     w_f_ready;
    t_div_bus w_f_bus;
    logic     w_d_valid;
    logic     w_d_ready;
    t_div_bus w_d_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ndc_base      <= RST_NDC_BASE;
            r_ndc_numerator <= RST_NDC_NUMERATOR;
            r_clip_near     <= RST_CLIP_NEAR;
            r_clip_far      <= RST_CLIP_FAR;
            r_range_scale   <= RST_RANGE_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NDC_BASE:      r_ndc_base      <= i_cfg_wdata;
                REG_NDC_NUMERATOR: r_ndc_numerator <= i_cfg_wdata;
                REG_CLIP_NEAR:     r_clip_near     <= i_cfg_wdata;
                REG_CLIP_FAR:      r_clip_far      <= i_cfg_wdata;
                REG_RANGE_SCALE:   r_range_scale   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dlc_front #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_depth_valid),
        .o_ready  (o_depth_ready),
        .i_sample (i_depth_sample),
        .i_base   (r_ndc_base),
        .i_num    (r_ndc_numerator),
        .o_valid  (w_f_valid),
        .i_ready  (w_f_ready),
        .o_bus    (w_f_bus)
    );

    dlc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_bus   (w_f_bus),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_bus   (w_d_bus)
    );

    dlc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_d_valid),
        .o_ready        (w_d_ready),
        .i_bus          (w_d_bus),
        .i_near         (r_clip_near),
        .i_far          (r_clip_far),
        .i_scale        (r_range_scale),
        .o_valid        (o_code_valid),
        .i_ready        (i_code_ready),
        .o_code_swapped (o_depth_code_swapped)
    );

endmodule
`default_nettype wire

[rtl/core/dlc_checker.sv]
// Port-level checks for the depth linearize and clamp block, bound to the
// top level. Depends on dlc_pkg and depth_linearize_clamp_16bit.
`default_nettype none
module dlc_checker
    import dlc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_depth_ready,
    input wire logic                  o_code_valid,
    input wire logic                  i_code_ready,
    input wire logic [DLC_CODE_W-1:0] o_depth_code_swapped
);

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_code_valid && o_depth_ready))
        else $error("pipeline not empty after reset");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_code_valid |-> o_depth_ready)
        else $error("input stalled while output register is free");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_code_valid && !i_code_ready))
            |-> (o_code_valid && $stable(o_depth_code_swapped)))
        else $error("stalled transaction changed or dropped");

    a_fall_only_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_code_valid)) |-> $past(i_code_ready))
        else $error("output transaction lost without handshake");

endmodule

bind depth_linearize_clamp_16bit dlc_checker u_dlc_checker (.*);
`default_nettype wire

[sim/tb_depth_linearize_clamp_16bit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for depth_linearize_clamp_16bit: directed table then random phases,
// each code checked vs a listed code or fixed-point linearization model. Depends on dlc_pkg.
module tb_depth_linearize_clamp_16bit;
    import dlc_pkg::*;

    localparam int DIR_ROWS    = 38;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 94;
    localparam int NUM_REGS    = int'(REG_RANGE_SCALE) + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 48;

    localparam logic [DLC_IDX_W-1:0] IDX_UNMAPPED = 3'd7;

    typedef enum bit {ROW_WRITE, ROW_SAMPLE} t_row_kind;
    typedef enum int {PH_DEFAULTS, PH_ZEROS, PH_ONES, PH_RAW, PH_CAMERA} t_phase_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [DLC_IDX_W-1:0]   idx;
        logic [DLC_REG_W-1:0]   data;
        bit                     lit_ok;
        logic [DLC_CODE_W-1:0]  lit_code;
    } t_dir_row;

    localparam t_phase_kind PHASE_PLAN [NUM_PHASES] = '{
        PH_DEFAULTS, PH_ZEROS, PH_CAMERA, PH_ONES, PH_CAMERA, PH_RAW, PH_CAMERA, PH_CAMERA
    };

    logic                      i_clk;
    logic                      i_rst_n              = 1'b0;
    logic                      i_depth_valid        = 1'b0;
    logic                      o_depth_ready;
    logic [DLC_DEPTH_BITS-1:0] i_depth_sample       = '0;
    logic                      o_code_valid;
    logic                      i_code_ready         = 1'b0;
    logic [DLC_CODE_W-1:0]     o_depth_code_swapped;
    logic                      i_cfg_we             = 1'b0;
    logic [DLC_IDX_W-1:0]      i_cfg_idx            = '0;
    logic [DLC_REG_W-1:0]      i_cfg_wdata          = '0;

    logic [DLC_REG_W-1:0]  base_q4_28 = RST_NDC_BASE;
    logic [DLC_REG_W-1:0]  numer_q16  = RST_NDC_NUMERATOR;
    logic [DLC_REG_W-1:0]  near_q16   = RST_CLIP_NEAR;
    logic [DLC_REG_W-1:0]  far_q16    = RST_CLIP_FAR;
    logic [DLC_REG_W-1:0]  scale_q16  = RST_RANGE_SCALE;

    logic [DLC_CODE_W-1:0] code_fifo [$];
    int                    mismatch_cnt = 0;
    int                    cycle_cnt    = 0;
    int                    burst_left   = 0;
    int                    rdy_left     = 0;
    bit                    cfg_open     = 1'b0;
    t_dir_row              dir_rows [DIR_ROWS];

    depth_linearize_clamp_16bit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_depth_valid        (i_depth_valid),
        .o_depth_ready        (o_depth_ready),
        .i_depth_sample       (i_depth_sample),
        .o_code_valid         (o_code_valid),
        .i_code_ready         (i_code_ready),
        .o_depth_code_swapped (o_depth_code_swapped),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [DLC_CODE_W-1:0] linear_depth_code(
        input logic [DLC_DEPTH_BITS-1:0] s
    );
        logic [63:0]           sub;
        logic [63:0]           add;
        logic [63:0]           den;
        logic [63:0]           z;
        logic [63:0]           prod;
        logic [DLC_CODE_W-1:0] code;
        sub = 64'(s) << (33 - DLC_DEPTH_BITS);
        add = (64'(base_q4_28) << 4) + (64'd1 << DLC_NDC_ONE);
        if (add <= sub) begin
            code = DLC_CODE_MAX;
        end else begin
            den = add - sub;
            if (64'(numer_q16) >= den) begin
                code = DLC_CODE_MAX;
            end else begin
                z = (64'(numer_q16) << DLC_NDC_ONE) / den;
                if (z <= 64'(near_q16)) begin
                    code = DLC_CODE_ZERO;
                end else if (z >= 64'(far_q16)) begin
                    code = DLC_CODE_MAX;
                end else begin
                    prod = ((z - 64'(near_q16)) * 64'(scale_q16)) >> DLC_REG_W;
                    code = (prod > 64'(DLC_CODE_MAX)) ? DLC_CODE_MAX : prod[DLC_CODE_W-1:0];
                end
            end
        end
        return {code[7:0], code[15:8]};
    endfunction

    function automatic logic [DLC_REG_W-1:0] to_fixed(input real v, input real one);
        real x;
        x = v * one;
        if (x >= 4294967295.0)
            return '1;
        if (x <= 0.0)
            return '0;
        return DLC_REG_W'(longint'(x));
    endfunction

    function automatic t_dir_row sample_row(input logic [DLC_DEPTH_BITS-1:0] s);
        return '{ROW_SAMPLE, IDX_UNMAPPED, DLC_REG_W'(s), 1'b0, DLC_CODE_ZERO};
    endfunction

    function automatic t_dir_row known_row(input logic [DLC_DEPTH_BITS-1:0] s,
                                           input logic [DLC_CODE_W-1:0] code);
        return '{ROW_SAMPLE, IDX_UNMAPPED, DLC_REG_W'(s), 1'b1, code};
    endfunction

    function automatic t_dir_row write_row(input logic [DLC_IDX_W-1:0] idx,
                                           input logic [DLC_REG_W-1:0] v);
        return '{ROW_WRITE, idx, v, 1'b0, DLC_CODE_ZERO};
    endfunction

    task automatic write_reg(input logic [DLC_IDX_W-1:0] idx, input logic [DLC_REG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        cfg_open     = 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_NDC_BASE:      base_q4_28 = v;
            REG_NDC_NUMERATOR: numer_q16  = v;
            REG_CLIP_NEAR:     near_q16   = v;
            REG_CLIP_FAR:      far_q16    = v;
            REG_RANGE_SCALE:   scale_q16  = v;
            default: ;
        endcase
    endtask

    task automatic send_depth(input logic [DLC_DEPTH_BITS-1:0] s, input bit lit_ok,
                              input logic [DLC_CODE_W-1:0] lit_code);
        int gap;
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open  = 1'b0;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_depth_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_depth_valid  <= 1'b1;
        i_depth_sample <= s;
        do @(posedge i_clk); while (o_depth_ready !== 1'b1);
        code_fifo.push_back(lit_ok ? lit_code : linear_depth_code(s));
    endtask

    task automatic drain_codes();
        i_depth_valid <= 1'b0;
        burst_left     = 0;
        while (code_fifo.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_depth_linearize_clamp_16bit: done, errors");
            $finish;
        end
    end

    // check accepted codes, then advance the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_code_valid === 1'b1 && i_code_ready) begin
            if (code_fifo.size() == 0) begin
                $error("depth_code_swapped: unexpected transaction, got %h",
                       o_depth_code_swapped);
                mismatch_cnt++;
            end else if (o_depth_code_swapped !== code_fifo[0]) begin
                $error("depth_code_swapped: expected %h, got %h",
                       code_fifo[0], o_depth_code_swapped);
                mismatch_cnt++;
                void'(code_fifo.pop_front());
            end else begin
                void'(code_fifo.pop_front());
            end
        end
        if (rdy_left == 0) begin
            if (i_code_ready) begin
                i_code_ready <= 1'b0;
                rdy_left      = $urandom_range(1, 10);
            end else begin
                i_code_ready <= 1'b1;
                rdy_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 8);
            end
        end else begin
            rdy_left--;
        end
    end

    initial begin
        logic [DLC_DEPTH_BITS-1:0] s;
        logic [DLC_REG_W-1:0]      setting [NUM_REGS];
        real                       near_pl;
        real                       far_pl;
        real                       lo;
        real                       hi;
        real                       sc;
        int                        k;

        dir_rows = '{
            sample_row(24'h000000), sample_row(24'hFFFFFF), sample_row(24'h800000),
            sample_row(24'h7FFFFF), sample_row(24'h000001), sample_row(24'hAAAAAA),
            sample_row(24'h555555),
            write_row(REG_NDC_BASE, 32'h0000_0000),
            known_row(24'h800000, DLC_CODE_MAX),
            known_row(24'hFFFFFF, DLC_CODE_MAX),
            known_row(24'h7FFFFF, DLC_CODE_MAX),
            sample_row(24'h000000),
            write_row(REG_NDC_NUMERATOR, 32'h0000_0000),
            known_row(24'h000000, DLC_CODE_ZERO),
            known_row(24'h7FFFFF, DLC_CODE_ZERO),
            write_row(REG_NDC_NUMERATOR, 32'hFFFF_FFFF),
            known_row(24'h000000, DLC_CODE_MAX),
            write_row(REG_NDC_BASE, 32'hFFFF_FFFF),
            sample_row(24'hFFFFFF), sample_row(24'h000000),
            write_row(REG_CLIP_NEAR, 32'hFFFF_FFFF),
            write_row(REG_CLIP_FAR, 32'h0000_0000),
            known_row(24'h123456, DLC_CODE_ZERO),
            write_row(REG_CLIP_NEAR, 32'h0000_0000),
            write_row(REG_CLIP_FAR, 32'hFFFF_FFFF),
            write_row(REG_RANGE_SCALE, 32'hFFFF_FFFF),
            known_row(24'h000000, DLC_CODE_MAX),
            write_row(REG_RANGE_SCALE, 32'h0000_0000),
            known_row(24'h3C0F0F, DLC_CODE_ZERO),
            write_row(IDX_UNMAPPED, 32'hDEAD_BEEF),
            sample_row(24'h00FF00),
            write_row(REG_NDC_BASE, RST_NDC_BASE),
            write_row(REG_NDC_NUMERATOR, RST_NDC_NUMERATOR),
            write_row(REG_CLIP_NEAR, RST_CLIP_NEAR),
            write_row(REG_CLIP_FAR, RST_CLIP_FAR),
            write_row(REG_RANGE_SCALE, RST_RANGE_SCALE),
            sample_row(24'hC00000), sample_row(24'h0F0F0F)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                drain_codes();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_depth(dir_rows[r].data[DLC_DEPTH_BITS-1:0], dir_rows[r].lit_ok,
                           dir_rows[r].lit_code);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_codes();
            case (PHASE_PLAN[ph])
                PH_DEFAULTS: setting = '{RST_NDC_BASE, RST_NDC_NUMERATOR, RST_CLIP_NEAR,
                                         RST_CLIP_FAR, RST_RANGE_SCALE};
                PH_ZEROS:    setting = '{default: '0};
                PH_ONES:     setting = '{default: '1};
                PH_RAW: begin
                    foreach (setting[i])
                        setting[i] = $urandom();
                end
                default: begin
                    // derive a consistent camera, slightly overdriven scale
                    near_pl = 0.5 + $urandom_range(0, 4000) / 100.0;
                    far_pl  = near_pl * (2.0 + $urandom_range(0, 5000) / 10.0);
                    lo = near_pl + (far_pl - near_pl) * $urandom_range(0, 30) / 100.0;
                    hi = lo + (far_pl - lo) * (5 + $urandom_range(0, 95)) / 100.0;
                    sc = 65535.0 / (hi - lo) * (1.0 + $urandom_range(0, 3) / 100.0);
                    setting[REG_NDC_BASE] =
                        to_fixed((far_pl + near_pl) / (far_pl - near_pl), 268435456.0);
                    setting[REG_NDC_NUMERATOR] =
                        to_fixed(2.0 * far_pl * near_pl / (far_pl - near_pl), 65536.0);
                    setting[REG_CLIP_NEAR]   = to_fixed(lo, 65536.0);
                    setting[REG_CLIP_FAR]    = to_fixed(hi, 65536.0);
                    setting[REG_RANGE_SCALE] = to_fixed(sc, 65536.0);
                end
            endcase
            for (int ri = 0; ri < NUM_REGS; ri++)
                write_reg(DLC_IDX_W'(ri), setting[ri]);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: s = DLC_DEPTH_BITS'($urandom());
                    4, 5, 6, 7: begin
                        k = $urandom_range(4, 20);
                        s = 24'hFFFFFF - DLC_DEPTH_BITS'($urandom_range(0, (1 << k) - 1));
                    end
                    8: begin
                        case ($urandom_range(0, 3))
                            0:       s = 24'h000000;
                            1:       s = 24'hFFFFFF;
                            2:       s = 24'h800000;
                            default: s = 24'h7FFFFF;
                        endcase
                    end
                    default: begin
                        s = DLC_DEPTH_BITS'(1) << $urandom_range(0, DLC_DEPTH_BITS - 1);
                        if ($urandom_range(0, 1) == 1)
                            s = ~s;
                    end
                endcase
                send_depth(s, 1'b0, DLC_CODE_ZERO);
            end
        end

        if (cfg_open)
            i_cfg_we <= 1'b0;
        drain_codes();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && code_fifo.size() == 0) begin
            $display("tb_depth_linearize_clamp_16bit: done, clean");
        end else begin
            $display("tb_depth_linearize_clamp_16bit: done, errors");
        end
        $finish;
    end

endmodule
